// ----- sv/nfsg_pkg.sv -----
// shared types and constants for the nor flash sector geometry block
// no dependencies; imported by every other file of the block
package nfsg_pkg;

    localparam int WORD_COUNT = 4;
    localparam int IDX_W      = 2;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_MISS      = 2'd1;
    localparam logic [1:0] STAT_BAD_GEO   = 2'd2;
    localparam logic [1:0] STAT_BAD_RANGE = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_TOTAL   = 3'd0;
    localparam logic [2:0] REG_TOPDOWN = 3'd1;
    localparam logic [2:0] REG_DEVICE  = 3'd2;
    localparam logic [2:0] REG_WORD_A  = 3'd3;
    localparam logic [2:0] REG_WORD_B  = 3'd4;
    localparam logic [2:0] REG_WORD_C  = 3'd5;
    localparam logic [2:0] REG_WORD_D  = 3'd6;

    localparam logic [63:0] WORD_A_RESET = 64'd274877972480;

    typedef enum logic [3:0] {
        ST_BSTART,
        ST_BMUL,
        ST_BACC,
        ST_BCHK,
        ST_BLAY,
        ST_IDLE,
        ST_LOOK,
        ST_SDIV,
        ST_WALK,
        ST_WDIV,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_BSTART,
        OP_BMUL,
        OP_BACC,
        OP_BCHK,
        OP_BLAY,
        OP_QLOAD,
        OP_LOOK,
        OP_SECT,
        OP_WALK,
        OP_WACC,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic cfg_bad;
        logic acc_fail;
        logic acc_last;
        logic chk_fail;
        logic lay_last;
        logic look_stop;
        logic div_done;
        logic func1;
        logic walk_stop;
        logic wacc_stop;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic [31:0] ebytes;
        logic [31:0] secs;
        logic [1:0]  region;
        logic [31:0] bytes;
        logic [31:0] stop;
        logic [31:0] start;
        logic [1:0]  status;
    } res_t;

endpackage

// ----- sv/nfsg_div.sv -----
// restoring divider, 33-bit dividend by 32-bit divisor, one bit a cycle
// depends on nfsg_pkg
module nfsg_div
    import nfsg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [32:0] quo,
    output logic [31:0] rem
);

    localparam int STEPS = 33;

    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] div_reg;
    logic [32:0] trial;
    logic [32:0] diff;

    assign trial = {rem_reg, quo_reg[32]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[31:0], 1'b1};
            end else begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[31:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- sv/nfsg_dp.sv -----
// datapath: configuration registers, region map, query arithmetic, output register
// depends on nfsg_pkg and nfsg_div
module nfsg_dp
    import nfsg_pkg::*;
#(
    parameter int REGION_SLOTS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [63:0] cfg_data,
    input  logic        in_func,
    input  logic [31:0] in_first,
    input  logic [31:0] in_last,
    input  logic        out_ready,
    output logic        out_valid,
    output res_t        out_res,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat
);

    // configuration
    logic [2:0]  total_reg;
    logic        topdown_reg;
    logic [31:0] dev_reg;
    logic [63:0] word_reg [WORD_COUNT];

    // map
    logic [31:0] base_reg  [WORD_COUNT];
    logic [31:0] limit_reg [WORD_COUNT];
    logic [31:0] sect_reg  [WORD_COUNT];
    logic [31:0] span_reg  [WORD_COUNT];
    logic        map_ok_reg;
    logic [63:0] prod_reg;
    logic [31:0] tot_reg;
    logic [31:0] cur_reg;
    logic [IDX_W-1:0] i_reg;

    // query
    logic        func_reg;
    logic [31:0] first_reg;
    logic [31:0] last_reg;
    logic [IDX_W-1:0] r_reg;
    logic        from_base_reg;
    logic [31:0] addr_reg;
    logic [32:0] rend_reg;
    logic [32:0] x_reg;
    logic [35:0] secs_reg;
    logic [35:0] bytes_reg;
    res_t        res_reg;
    res_t        m_res_reg;
    logic        m_valid_reg;

    logic [IDX_W-1:0] n_m1;
    logic [31:0] cnt_i;
    logic [31:0] sz_i;
    logic [32:0] acc_sum;
    logic [IDX_W-1:0] dst;
    logic [WORD_COUNT-1:0] hit_vec;
    logic [IDX_W-1:0] hit_idx;
    logic        found;
    logic [IDX_W-1:0] rd_idx;
    logic [31:0] rd_base;
    logic [31:0] rd_limit;
    logic [31:0] rd_sect;
    logic [32:0] end_x;
    logic [31:0] walk_addr;
    logic [32:0] rend;
    logic        div_go;
    logic [32:0] div_dvd;
    logic        div_busy;
    logic        div_done;
    logic [32:0] div_quo;
    logic [31:0] div_rem;
    logic [33:0] k_add;
    logic [33:0] b_add;

    assign n_m1    = IDX_W'(total_reg - 3'd1);
    assign cnt_i   = word_reg[i_reg][63:32];
    assign sz_i    = word_reg[i_reg][31:0];
    assign acc_sum = {1'b0, tot_reg} + {1'b0, prod_reg[31:0]};
    assign dst     = topdown_reg ? IDX_W'(n_m1 - i_reg) : i_reg;

    // lowest map region holding the address wins
    always_comb begin
        hit_idx = '0;
        found   = 1'b0;
        for (int j = WORD_COUNT - 1; j >= 0; j--) begin
            hit_vec[j] = (32'(j) < 32'(total_reg)) && (first_reg >= base_reg[j])
                         && (first_reg < limit_reg[j]);
            if (hit_vec[j]) begin
                hit_idx = IDX_W'(j);
                found   = 1'b1;
            end
        end
    end

    assign rd_idx    = (cmd.op == OP_LOOK) ? hit_idx : r_reg;
    assign rd_base   = base_reg[rd_idx];
    assign rd_limit  = limit_reg[rd_idx];
    assign rd_sect   = sect_reg[rd_idx];
    assign end_x     = {1'b0, last_reg} + 33'd1;
    assign walk_addr = from_base_reg ? rd_base : addr_reg;
    assign rend      = ({1'b0, rd_limit} > end_x) ? end_x : {1'b0, rd_limit};

    assign k_add = {1'b0, div_quo} + {33'b0, (div_rem != 32'd0)};
    assign b_add = (div_rem == 32'd0) ? {1'b0, x_reg}
                 : {1'b0, x_reg} + {2'b0, rd_sect} - {2'b0, div_rem};

    assign div_go  = ((cmd.op == OP_LOOK) && !stat.look_stop)
                  || ((cmd.op == OP_WALK) && !stat.walk_stop);
    assign div_dvd = (cmd.op == OP_LOOK) ? {1'b0, first_reg - rd_base}
                                         : rend - {1'b0, walk_addr};

    nfsg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_go),
        .dividend (div_dvd),
        .divisor  (rd_sect),
        .busy     (div_busy),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    always_comb begin
        stat.cfg_bad   = (total_reg == 3'd0) || (total_reg > 3'(WORD_COUNT))
                      || (32'(total_reg) > REGION_SLOTS);
        stat.acc_fail  = (cnt_i == 32'd0) || (sz_i == 32'd0)
                      || (prod_reg[63:32] != 32'd0) || acc_sum[32];
        stat.acc_last  = (i_reg == n_m1);
        stat.chk_fail  = (dev_reg != 32'd0) && (dev_reg != tot_reg);
        stat.lay_last  = (i_reg == n_m1);
        stat.look_stop = !map_ok_reg || (func_reg && (last_reg < first_reg)) || !found;
        stat.div_done  = div_done;
        stat.func1     = func_reg;
        stat.walk_stop = (rend <= {1'b0, walk_addr});
        stat.wacc_stop = (rend_reg >= end_x) || (r_reg == n_m1);
        stat.out_free  = !m_valid_reg || out_ready;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= 3'd1;
            topdown_reg <= 1'b0;
            dev_reg     <= '0;
            word_reg[0] <= WORD_A_RESET;
            word_reg[1] <= '0;
            word_reg[2] <= '0;
            word_reg[3] <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_TOTAL:   total_reg   <= cfg_data[2:0];
                REG_TOPDOWN: topdown_reg <= cfg_data[0];
                REG_DEVICE:  dev_reg     <= cfg_data[31:0];
                REG_WORD_A:  word_reg[0] <= cfg_data;
                REG_WORD_B:  word_reg[1] <= cfg_data;
                REG_WORD_C:  word_reg[2] <= cfg_data;
                REG_WORD_D:  word_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // map build
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_ok_reg <= 1'b0;
            i_reg      <= '0;
        end else begin
            unique case (cmd.op)
                OP_BSTART: begin
                    map_ok_reg <= 1'b0;
                    i_reg      <= '0;
                end
                OP_BACC: begin
                    if (!stat.acc_fail && !stat.acc_last) begin
                        i_reg <= i_reg + IDX_W'(1);
                    end
                end
                OP_BCHK: i_reg <= '0;
                OP_BLAY: begin
                    i_reg <= i_reg + IDX_W'(1);
                    if (stat.lay_last) begin
                        map_ok_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_BSTART: tot_reg <= '0;
            OP_BMUL:   prod_reg <= cnt_i * sz_i;
            OP_BACC: begin
                span_reg[i_reg] <= prod_reg[31:0];
                tot_reg         <= acc_sum[31:0];
            end
            OP_BCHK:   cur_reg <= topdown_reg ? tot_reg : 32'd0;
            OP_BLAY: begin
                sect_reg[dst] <= sz_i;
                if (topdown_reg) begin
                    base_reg[dst]  <= cur_reg - span_reg[i_reg];
                    limit_reg[dst] <= cur_reg;
                    cur_reg        <= cur_reg - span_reg[i_reg];
                end else begin
                    base_reg[dst]  <= cur_reg;
                    limit_reg[dst] <= cur_reg + span_reg[i_reg];
                    cur_reg        <= cur_reg + span_reg[i_reg];
                end
            end
            default: ;
        endcase
    end

    // query
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_QLOAD: begin
                func_reg  <= in_func;
                first_reg <= in_first;
                last_reg  <= in_last;
                res_reg   <= '0;
                secs_reg  <= '0;
                bytes_reg <= '0;
            end
            OP_LOOK: begin
                r_reg         <= hit_idx;
                from_base_reg <= 1'b0;
                if (!map_ok_reg) begin
                    res_reg.status <= STAT_BAD_GEO;
                end else if (func_reg && (last_reg < first_reg)) begin
                    res_reg.status <= STAT_BAD_RANGE;
                end else if (!found) begin
                    res_reg.status <= STAT_MISS;
                end
            end
            OP_SECT: begin
                if (div_done) begin
                    res_reg.start  <= first_reg - div_rem;
                    res_reg.stop   <= first_reg - div_rem + rd_sect;
                    res_reg.bytes  <= rd_sect;
                    res_reg.region <= r_reg;
                    addr_reg       <= first_reg - div_rem;
                end
            end
            OP_WALK: begin
                rend_reg <= rend;
                x_reg    <= rend - {1'b0, walk_addr};
            end
            OP_WACC: begin
                if (div_done) begin
                    secs_reg  <= secs_reg + {2'b0, k_add};
                    bytes_reg <= bytes_reg + {2'b0, b_add};
                    if (!stat.wacc_stop) begin
                        r_reg         <= r_reg + IDX_W'(1);
                        from_base_reg <= 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // output register, saturating the range totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((cmd.op == OP_OUT) && stat.out_free) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((cmd.op == OP_OUT) && stat.out_free) begin
            m_res_reg        <= res_reg;
            m_res_reg.secs   <= (secs_reg[35:32] != 4'd0) ? MAX32 : secs_reg[31:0];
            m_res_reg.ebytes <= (bytes_reg[35:32] != 4'd0) ? MAX32 : bytes_reg[31:0];
        end
    end

    assign out_valid = m_valid_reg;
    assign out_res   = m_res_reg;

`ifndef NO_ASSERTIONS
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_go |-> !div_busy)
        else $error("divider started while busy");
    a_map_from_layout: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(map_ok_reg) |-> $past(cmd.op) == OP_BLAY)
        else $error("map marked valid outside layout pass");
    a_load_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.op) == OP_OUT)
        else $error("result word raised outside output step");
    a_bad_geo_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_res_reg.status == STAT_BAD_GEO) |->
            (m_res_reg.start == 32'd0) && (m_res_reg.secs == 32'd0))
        else $error("rejected map gave nonzero fields");
`endif

endmodule

// ----- sv/nfsg_ctrl.sv -----
// controller state machine: map build sequence and query sequence
// depends on nfsg_pkg; drives the datapath by command, reads its status
module nfsg_ctrl
    import nfsg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cfg_we,
    input  logic     in_valid,
    output logic     in_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_BSTART;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        if (cfg_we) begin
            state_next = ST_BSTART;
        end else begin
            unique case (state_reg)
                ST_BSTART: state_next = stat.cfg_bad ? ST_IDLE : ST_BMUL;
                ST_BMUL:   state_next = ST_BACC;
                ST_BACC: begin
                    priority if (stat.acc_fail) state_next = ST_IDLE;
                    else if (stat.acc_last)     state_next = ST_BCHK;
                    else                        state_next = ST_BMUL;
                end
                ST_BCHK:   state_next = stat.chk_fail ? ST_IDLE : ST_BLAY;
                ST_BLAY:   state_next = stat.lay_last ? ST_IDLE : ST_BLAY;
                ST_IDLE:   state_next = in_valid ? ST_LOOK : ST_IDLE;
                ST_LOOK:   state_next = stat.look_stop ? ST_OUT : ST_SDIV;
                ST_SDIV: begin
                    if (stat.div_done) begin
                        state_next = stat.func1 ? ST_WALK : ST_OUT;
                    end
                end
                ST_WALK:   state_next = stat.walk_stop ? ST_OUT : ST_WDIV;
                ST_WDIV: begin
                    if (stat.div_done) begin
                        state_next = stat.wacc_stop ? ST_OUT : ST_WALK;
                    end
                end
                ST_OUT:    state_next = stat.out_free ? ST_IDLE : ST_OUT;
                default:   state_next = ST_BSTART;
            endcase
        end
    end

    always_comb begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            ST_BSTART: cmd.op = OP_BSTART;
            ST_BMUL:   cmd.op = OP_BMUL;
            ST_BACC:   cmd.op = OP_BACC;
            ST_BCHK:   cmd.op = OP_BCHK;
            ST_BLAY:   cmd.op = OP_BLAY;
            ST_IDLE: begin
                in_ready = !cfg_we;
                cmd.op   = (in_valid && !cfg_we) ? OP_QLOAD : OP_NONE;
            end
            ST_LOOK:   cmd.op = OP_LOOK;
            ST_SDIV:   cmd.op = OP_SECT;
            ST_WALK:   cmd.op = OP_WALK;
            ST_WDIV:   cmd.op = OP_WACC;
            ST_OUT:    cmd.op = OP_OUT;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

// ----- sv/nor_flash_sector_geometry.sv -----
// a bounds query (mode 0) takes one pass of the bit-serial divider; a range query
// (mode 1) takes one more pass for each region visited
// throughput: one query at a time; the next word is taken once the current result
// sits in the output register, so a stalled result does not block acceptance
// reset and every register write rebuild the region map, one multiply and one add per
// region, with s_tready low until the build ends, even when the map comes out invalid
module nor_flash_sector_geometry
    import nfsg_pkg::*;
#(
    parameter int REGION_SLOTS = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_we,
    input  logic [2:0]   cfg_idx,
    input  logic [63:0]  cfg_data,
    // query words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // addr_first, addr_last
    input  logic         s_tuser,   // func
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata    // status, sector_start, sector_stop, sector_bytes,
                                    // region_hit, range_sectors, range_erase_bytes, pad
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    res_t     res;

    // sequencer for map build and query steps
    nfsg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // registers, map, divider and result register
    nfsg_dp #(
        .REGION_SLOTS (REGION_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .in_func   (s_tuser),
        .in_first  (s_tdata[31:0]),
        .in_last   (s_tdata[63:32]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (res),
        .cmd       (cmd),
        .stat      (stat)
    );

    // struct packs status in the lowest bits
    assign m_tdata = {4'b0, res};

endmodule
